### rtl/tna_pkg.sv
`default_nettype none
package tna_pkg;
    localparam int NORM_BITS = 16;
    localparam int AREA_BITS = 49;
    localparam int FRAC_Q    = 15;
    localparam logic [NORM_BITS-1:0] NORM_POS_MAX = 16'h7FFF;
    localparam logic [AREA_BITS-1:0] AREA_MAX = {AREA_BITS{1'b1}};
endpackage
`default_nettype wire

### rtl/triangle_normal_and_area_core.sv
`default_nettype none
// Channel   | direction | handshake           | payload
// request   | in        | start / busy        | ax..cz, has_three_corners
// result    | out       | done (one cycle)    | normal_x/y/z, area, degenerate
//
// Pipeline: edges, cross products, cross terms, half-width partial squares,
// squares, squared length, then a square root with one stage per result bit,
// then a divider with one stage per quotient bit, then the output register.
// One request is taken every cycle.
// busy is tied low: the pipeline never stalls, the receiver cannot hold off.
// rst_n clears the valid bits only; payload registers carry no reset.
module triangle_normal_and_area_core
    import tna_pkg::*;
#(
    parameter int COORD_BITS = 24
)(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire  signed [COORD_BITS-1:0] ax,
    input  wire  signed [COORD_BITS-1:0] ay,
    input  wire  signed [COORD_BITS-1:0] az,
    input  wire  signed [COORD_BITS-1:0] bx,
    input  wire  signed [COORD_BITS-1:0] by,
    input  wire  signed [COORD_BITS-1:0] bz,
    input  wire  signed [COORD_BITS-1:0] cx,
    input  wire  signed [COORD_BITS-1:0] cy,
    input  wire  signed [COORD_BITS-1:0] cz,
    input  wire                          has_three_corners,
    output logic                         done,
    output logic signed [NORM_BITS-1:0]  normal_x,
    output logic signed [NORM_BITS-1:0]  normal_y,
    output logic signed [NORM_BITS-1:0]  normal_z,
    output logic        [AREA_BITS-1:0]  area,
    output logic                         degenerate
);
    localparam int EB = COORD_BITS + 1;          // edge width
    localparam int PB = 2 * EB;                  // product width
    localparam int XB = PB + 1;                  // cross term width (signed)
    localparam int MB = XB - 1;                  // magnitude width
    localparam int SB = 2 * MB + 2;              // sum of squares
    localparam int SQ_BITS = SB / 2;             // root width
    localparam int NB = MB + FRAC_Q;             // dividend width
    localparam int QD_BITS = FRAC_Q + 2;         // quotient bits kept (<= 2^16)
    localparam int RB = SQ_BITS + 1;             // remainder width
    localparam int HW = MB / 2;                  // half magnitude width

    assign busy = 1'b0;
    wire acc = start;

    // stage 1: edges
    logic                 v1_reg, h1_reg;
    logic signed [EB-1:0] e1x_reg, e1y_reg, e1z_reg, e2x_reg, e2y_reg, e2z_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= acc;
    end
    always_ff @(posedge clk)
    begin
        h1_reg  <= has_three_corners;
        e1x_reg <= EB'(bx) - EB'(ax);
        e1y_reg <= EB'(by) - EB'(ay);
        e1z_reg <= EB'(bz) - EB'(az);
        e2x_reg <= EB'(cx) - EB'(bx);
        e2y_reg <= EB'(cy) - EB'(by);
        e2z_reg <= EB'(cz) - EB'(bz);
    end

    // stage 2: six products
    logic                 v2_reg, h2_reg;
    logic signed [PB-1:0] p_reg [6];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        h2_reg   <= h1_reg;
        p_reg[0] <= PB'(e1y_reg) * PB'(e2z_reg);
        p_reg[1] <= PB'(e1z_reg) * PB'(e2y_reg);
        p_reg[2] <= PB'(e1z_reg) * PB'(e2x_reg);
        p_reg[3] <= PB'(e1x_reg) * PB'(e2z_reg);
        p_reg[4] <= PB'(e1x_reg) * PB'(e2y_reg);
        p_reg[5] <= PB'(e1y_reg) * PB'(e2x_reg);
    end

    // stage 3: cross terms, signs and magnitudes
    logic          v3_reg, h3_reg;
    logic          s3_reg [3];
    logic [MB-1:0] m3_reg [3];
    logic signed [XB-1:0] xt [3];
    always_comb
    begin
        xt[0] = XB'(p_reg[0]) - XB'(p_reg[1]);
        xt[1] = XB'(p_reg[2]) - XB'(p_reg[3]);
        xt[2] = XB'(p_reg[4]) - XB'(p_reg[5]);
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end
    always_ff @(posedge clk)
    begin
        h3_reg <= h2_reg;
        for (int i = 0; i < 3; i++)
        begin
            s3_reg[i] <= xt[i][XB-1];
            m3_reg[i] <= xt[i][XB-1] ? MB'(-xt[i]) : MB'(xt[i]);
        end
    end

    // stage 4a: partial squares, magnitude cut into high and low halves
    logic          v4a_reg, h4a_reg;
    logic          s4a_reg [3];
    logic [MB-1:0] m4a_reg [3];
    logic [MB-1:0] pll_reg [3];
    logic [MB-1:0] plh_reg [3];
    logic [MB-1:0] phh_reg [3];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4a_reg <= 1'b0;
        else
            v4a_reg <= v3_reg;
    end
    always_ff @(posedge clk)
    begin
        h4a_reg <= h3_reg;
        for (int i = 0; i < 3; i++)
        begin
            s4a_reg[i] <= s3_reg[i];
            m4a_reg[i] <= m3_reg[i];
            pll_reg[i] <= MB'(m3_reg[i][HW-1:0]) * MB'(m3_reg[i][HW-1:0]);
            plh_reg[i] <= MB'(m3_reg[i][MB-1:HW]) * MB'(m3_reg[i][HW-1:0]);
            phh_reg[i] <= MB'(m3_reg[i][MB-1:HW]) * MB'(m3_reg[i][MB-1:HW]);
        end
    end

    // stage 4: squares, hh:ll side by side plus twice the cross half
    logic          v4_reg, h4_reg;
    logic          s4_reg [3];
    logic [MB-1:0] m4_reg [3];
    logic [SB-1:0] q4_reg [3];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else
            v4_reg <= v4a_reg;
    end
    always_ff @(posedge clk)
    begin
        h4_reg <= h4a_reg;
        for (int i = 0; i < 3; i++)
        begin
            s4_reg[i] <= s4a_reg[i];
            m4_reg[i] <= m4a_reg[i];
            q4_reg[i] <= SB'({phh_reg[i], pll_reg[i]}) + (SB'(plh_reg[i]) << (HW + 1));
        end
    end

    // stage 5: sum and degenerate flag
    logic          v5_reg, d5_reg;
    logic          s5_reg [3];
    logic [MB-1:0] m5_reg [3];
    logic [SB-1:0] sum5_reg;
    logic [SB-1:0] sum5;
    assign sum5 = q4_reg[0] + q4_reg[1] + q4_reg[2];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else
            v5_reg <= v4_reg;
    end
    always_ff @(posedge clk)
    begin
        d5_reg   <= !h4_reg || (sum5 == '0);
        sum5_reg <= sum5;
        for (int i = 0; i < 3; i++)
        begin
            s5_reg[i] <= s4_reg[i];
            m5_reg[i] <= m4_reg[i];
        end
    end

    // square root: one result bit per stage, restoring
    logic               rv_reg [SQ_BITS+1];
    logic               rd_reg [SQ_BITS+1];
    logic               rs_reg [SQ_BITS+1][3];
    logic [MB-1:0]      rm_reg [SQ_BITS+1][3];
    logic [SB-1:0]      rrad_reg [SQ_BITS+1];
    logic [SB-1:0]      rrem_reg [SQ_BITS+1];
    logic [SQ_BITS-1:0] rroot_reg [SQ_BITS+1];
    always_comb
    begin
        rv_reg[0]    = v5_reg;
        rd_reg[0]    = d5_reg;
        rrad_reg[0]  = sum5_reg;
        rrem_reg[0]  = '0;
        rroot_reg[0] = '0;
        for (int i = 0; i < 3; i++)
        begin
            rs_reg[0][i] = s5_reg[i];
            rm_reg[0][i] = m5_reg[i];
        end
    end
    for (genvar k = 0; k < SQ_BITS; k++)
    begin : g_sqrt
        logic [SB+1:0] rem2, trial;
        always_comb
        begin
            rem2  = {rrem_reg[k], rrad_reg[k][SB-1 -: 2]};
            trial = {(SB+2-SQ_BITS-2)'(0), rroot_reg[k], 2'b01};
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rv_reg[k+1] <= 1'b0;
            else
                rv_reg[k+1] <= rv_reg[k];
        end
        always_ff @(posedge clk)
        begin
            rd_reg[k+1]   <= rd_reg[k];
            rrad_reg[k+1] <= rrad_reg[k] << 2;
            for (int i = 0; i < 3; i++)
            begin
                rs_reg[k+1][i] <= rs_reg[k][i];
                rm_reg[k+1][i] <= rm_reg[k][i];
            end
            if (rem2 >= trial)
            begin
                rrem_reg[k+1]  <= SB'(rem2 - trial);
                rroot_reg[k+1] <= {rroot_reg[k][SQ_BITS-2:0], 1'b1};
            end
            else
            begin
                rrem_reg[k+1]  <= SB'(rem2);
                rroot_reg[k+1] <= {rroot_reg[k][SQ_BITS-2:0], 1'b0};
            end
        end
    end

    // divider: |X_i| * 2^15 / L, low QD_BITS quotient bits plus overflow flag.
    // Leading dividend bits are folded into the initial remainder; any
    // quotient bit above the kept ones marks overflow (saturates).
    localparam int HB = NB - QD_BITS;
    logic               dv_reg [QD_BITS+1];
    logic               dd_reg [QD_BITS+1];
    logic               ds_reg [QD_BITS+1][3];
    logic               dov_reg [QD_BITS+1][3];
    logic [NB-1:0]      dn_reg [QD_BITS+1][3];
    logic [RB-1:0]      dr_reg [QD_BITS+1][3];
    logic [QD_BITS-1:0] dq_reg [QD_BITS+1][3];
    logic [SQ_BITS-1:0] dl_reg [QD_BITS+1];
    logic [NB-1:0]      num0 [3];
    always_comb
    begin
        dv_reg[0] = rv_reg[SQ_BITS];
        dd_reg[0] = rd_reg[SQ_BITS];
        dl_reg[0] = rroot_reg[SQ_BITS];
        for (int i = 0; i < 3; i++)
        begin
            num0[i]       = {rm_reg[SQ_BITS][i], FRAC_Q'(0)};
            ds_reg[0][i]  = rs_reg[SQ_BITS][i];
            // high part >= L means quotient >= 2^QD_BITS
            dov_reg[0][i] = (RB'(num0[i][NB-1 -: HB]) >= RB'(rroot_reg[SQ_BITS]));
            dr_reg[0][i]  = RB'(num0[i][NB-1 -: HB]);
            dn_reg[0][i]  = num0[i] << HB;
            dq_reg[0][i]  = '0;
        end
    end
    for (genvar k = 0; k < QD_BITS; k++)
    begin : g_div
        logic [RB:0] r2 [3];
        always_comb
        begin
            for (int i = 0; i < 3; i++)
                r2[i] = {dr_reg[k][i], dn_reg[k][i][NB-1]};
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[k+1] <= 1'b0;
            else
                dv_reg[k+1] <= dv_reg[k];
        end
        always_ff @(posedge clk)
        begin
            dd_reg[k+1] <= dd_reg[k];
            dl_reg[k+1] <= dl_reg[k];
            for (int i = 0; i < 3; i++)
            begin
                ds_reg[k+1][i]  <= ds_reg[k][i];
                dov_reg[k+1][i] <= dov_reg[k][i];
                dn_reg[k+1][i]  <= dn_reg[k][i] << 1;
                if (!dov_reg[k][i] && r2[i] >= (RB+1)'(dl_reg[k]))
                begin
                    dr_reg[k+1][i] <= RB'(r2[i] - (RB+1)'(dl_reg[k]));
                    dq_reg[k+1][i] <= {dq_reg[k][i][QD_BITS-2:0], 1'b1};
                end
                else
                begin
                    dr_reg[k+1][i] <= RB'(r2[i]);
                    dq_reg[k+1][i] <= {dq_reg[k][i][QD_BITS-2:0], 1'b0};
                end
            end
        end
    end

    // output stage: saturate, sign, area
    logic [NORM_BITS-1:0] nv [3];
    logic [NORM_BITS:0]   mag [3];
    logic [AREA_BITS-1:0] area_v;
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dov_reg[QD_BITS][i] || dq_reg[QD_BITS][i] > QD_BITS'(32768))
                mag[i] = 17'h10000 >> 1;
            else
                mag[i] = (NORM_BITS+1)'(dq_reg[QD_BITS][i]);
            if (ds_reg[QD_BITS][i])
                nv[i] = NORM_BITS'(17'h10000 - mag[i]);
            else if (mag[i] > 17'(NORM_POS_MAX))
                nv[i] = NORM_POS_MAX;
            else
                nv[i] = NORM_BITS'(mag[i]);
        end
        if ((SQ_BITS - 1) > AREA_BITS
            && (dl_reg[QD_BITS] >> (AREA_BITS + 1)) != '0)
            area_v = AREA_MAX;
        else
            area_v = AREA_BITS'(dl_reg[QD_BITS] >> 1);
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= dv_reg[QD_BITS];
    end
    always_ff @(posedge clk)
    begin
        degenerate <= dd_reg[QD_BITS];
        normal_x   <= dd_reg[QD_BITS] ? '0 : nv[0];
        normal_y   <= dd_reg[QD_BITS] ? '0 : nv[1];
        normal_z   <= dd_reg[QD_BITS] ? '0 : nv[2];
        area       <= dd_reg[QD_BITS] ? '0 : area_v;
    end

`ifndef NO_ASSERTIONS
    a_busy_low: assert property (@(posedge clk) busy == 1'b0)
        else $error("busy raised");
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(dv_reg[QD_BITS]))
        else $error("done without request");
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && degenerate) |-> (area == '0 && normal_x == '0))
        else $error("degenerate result not zero");
    a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_reg[QD_BITS] && !dd_reg[QD_BITS]) |-> dl_reg[QD_BITS] != '0)
        else $error("zero length on live face");
`endif
endmodule
`default_nettype wire

### dv/tb_triangle_normal_and_area_core.sv
`timescale 1ns / 1ps

module tb_triangle_normal_and_area_core;
    import tna_pkg::*;

    localparam int CB        = 24;
    localparam int SETTLE    = 400;   // comfortably beyond the pipeline latency
    localparam int STALL_MAX = 5000;  // cycles without any handshake before giving up

    typedef logic signed [CB-1:0] coord_t;

    // One triangle request; a hold entry makes the sender wait for the pipe to empty
    typedef struct {
        coord_t v[9];
        bit     corners;
        bit     hold;
    } tri_req_t;

    typedef struct {
        logic signed [NORM_BITS-1:0] nx, ny, nz;
        logic [AREA_BITS-1:0]        ar;
        logic                        degen;
    } face_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    coord_t ax = '0, ay = '0, az = '0, bx = '0, by = '0, bz = '0, cx = '0, cy = '0, cz = '0;
    logic has_three_corners = 1'b0;
    wire busy, done, degenerate;
    wire signed [NORM_BITS-1:0] normal_x, normal_y, normal_z;
    wire [AREA_BITS-1:0] area;

    tri_req_t  tri_backlog[$];
    face_res_t faces_due[$];
    tri_req_t  cur_tri;
    int        gap_left = 0;
    bit        calm = 1'b0;       // stretch with no idling on the sender
    int        n_sent = 0, n_checked = 0, n_degen = 0, n_bad = 0, idle_cycles = 0;

    triangle_normal_and_area_core #(.COORD_BITS(CB)) i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .ax(ax), .ay(ay), .az(az), .bx(bx), .by(by), .bz(bz),
        .cx(cx), .cy(cy), .cz(cz), .has_three_corners(has_three_corners),
        .done(done), .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .area(area), .degenerate(degenerate)
    );

    always #5 clk = ~clk;

    // Unit-normal component: trunc(|x| * 2^15 / len) with sign, +1.0 saturated
    function automatic logic [NORM_BITS-1:0] unit_comp(logic signed [127:0] x,
                                                       logic [127:0] len);
        logic [127:0] mag, q;
        mag = (x < 0) ? -x : x;
        q = (mag << FRAC_Q) / len;
        if (q > 128'd32768) q = 128'd32768;
        if (x < 0) return NORM_BITS'(17'h10000 - q[16:0]);
        if (q > 128'd32767) q = 128'd32767;
        return q[NORM_BITS-1:0];
    endfunction

    function automatic face_res_t face_normal_area(tri_req_t t);
        face_res_t    r;
        logic signed [127:0] e[6], xp, yp, zp;
        logic [127:0] sum, root, cand;
        for (int i = 0; i < 6; i++) e[i] = t.v[i+3] - t.v[i];  // B-A then C-B
        xp = e[1] * e[5] - e[2] * e[4];
        yp = e[2] * e[3] - e[0] * e[5];
        zp = e[0] * e[4] - e[1] * e[3];
        sum = xp * xp + yp * yp + zp * zp;
        r = '{default: '0};
        if (!t.corners || sum == 0)
        begin
            r.degen = 1'b1;
            return r;
        end
        root = '0;
        for (int b = 63; b >= 0; b--)
        begin
            cand = root | (128'd1 << b);
            if (cand * cand <= sum) root = cand;
        end
        r.nx = unit_comp(xp, root);
        r.ny = unit_comp(yp, root);
        r.nz = unit_comp(zp, root);
        r.ar = ((root >> 1) > {79'd0, AREA_MAX}) ? AREA_MAX : AREA_BITS'(root >> 1);
        return r;
    endfunction

    function automatic tri_req_t mk_tri(int a0, int a1, int a2, int b0, int b1, int b2,
                                        int c0, int c1, int c2, bit corners);
        tri_req_t t;
        t.v = '{coord_t'(a0), coord_t'(a1), coord_t'(a2), coord_t'(b0), coord_t'(b1),
                coord_t'(b2), coord_t'(c0), coord_t'(c1), coord_t'(c2)};
        t.corners = corners;
        t.hold = 1'b0;
        return t;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (calm || p < 60) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sender: one nonblocking update of start per edge
    always @(posedge clk)
    begin
        automatic bit next_start = start;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                faces_due.insert(faces_due.size(), face_normal_area(cur_tri));
                n_sent++;
                next_start = 1'b0;
                gap_left = pick_gap();
                if ($urandom_range(199) == 0) calm = !calm;
            end
            if (!next_start)
            begin
                if (gap_left > 0) gap_left--;
                else if (tri_backlog.size() > 0 && tri_backlog[0].hold)
                begin
                    if (faces_due.size() == 0) void'(tri_backlog.pop_front());
                end
                else if (tri_backlog.size() > 0)
                begin
                    cur_tri = tri_backlog.pop_front();
                    {ax, ay, az, bx, by, bz, cx, cy, cz} <= {cur_tri.v[0], cur_tri.v[1],
                        cur_tri.v[2], cur_tri.v[3], cur_tri.v[4], cur_tri.v[5],
                        cur_tri.v[6], cur_tri.v[7], cur_tri.v[8]};
                    has_three_corners <= cur_tri.corners;
                    next_start = 1'b1;
                end
            end
        end
        start <= next_start;
    end

    // Result checker: every done pulse is compared with the oldest prediction
    always @(posedge clk)
    begin
        automatic face_res_t want;
        if (rst_n && done)
        begin
            if (faces_due.size() == 0)
            begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected result at %0t", $realtime);
            end
            else
            begin
                want = faces_due.pop_front();
                n_checked++;
                if (want.degen) n_degen++;
                if (normal_x !== want.nx || normal_y !== want.ny || normal_z !== want.nz
                    || area !== want.ar || degenerate !== want.degen)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display({"mismatch #%0d: exp n=(%0d,%0d,%0d) a=%0d d=%0b",
                                  " got n=(%0d,%0d,%0d) a=%0d d=%0b"},
                                 n_checked, want.nx, want.ny, want.nz, want.ar, want.degen,
                                 normal_x, normal_y, normal_z, area, degenerate);
                end
            end
        end
    end

    // Watchdog on handshake activity
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= STALL_MAX)
        begin
            $display("watchdog: no progress for %0d cycles", STALL_MAX);
            $display("tb_triangle_normal_and_area_core: FAIL");
            $finish;
        end
    end

    initial
    begin
        tri_req_t t;
        int mx, mn, k, p;
        mx = 8388607;
        mn = -8388608;
        // Directed: unit normals on each axis (+1.0 saturates, -1.0 kept)
        tri_backlog.insert(tri_backlog.size(), mk_tri(0, 0, 0, 1, 0, 0, 1, 1, 0, 1));
        tri_backlog.insert(tri_backlog.size(), mk_tri(0, 0, 0, 0, 1, 0, 1, 1, 0, 1));
        tri_backlog.insert(tri_backlog.size(), mk_tri(0, 0, 0, 0, 1, 0, 0, 1, 1, 1));
        tri_backlog.insert(tri_backlog.size(), mk_tri(0, 0, 0, 0, 0, 1, 0, 1, 1, 1));
        tri_backlog.insert(tri_backlog.size(), mk_tri(0, 0, 0, 0, 0, 1, 1, 0, 1, 1));
        tri_backlog.insert(tri_backlog.size(), mk_tri(0, 0, 0, 1, 0, 0, 1, 0, 1, 1));
        // extreme corners, largest areas
        tri_backlog.insert(tri_backlog.size(), mk_tri(mn, mn, 0, mx, mn, 0, mx, mx, 0, 1));
        tri_backlog.insert(tri_backlog.size(),
                           mk_tri(mn, mn, mn, mx, mn, mx, mx, mx, mn, 1));
        tri_backlog.insert(tri_backlog.size(),
                           mk_tri(mx, mx, mx, mn, mx, mn, mn, mn, mx, 1));
        tri_backlog.insert(tri_backlog.size(),
                           mk_tri(mx, mn, mx, mn, mx, mn, mx, mx, mx, 1));
        // missing corners, collinear, coincident
        tri_backlog.insert(tri_backlog.size(),
                           mk_tri(mx, mn, mx, mn, mx, mn, mx, mx, mx, 0));
        tri_backlog.insert(tri_backlog.size(), mk_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        tri_backlog.insert(tri_backlog.size(),
                           mk_tri(mx, mx, mx, mx, mx, mx, mx, mx, mx, 1));
        tri_backlog.insert(tri_backlog.size(),
                           mk_tri(mn, mn, mn, 0, 0, 0, mx, mx, mx, 1));
        tri_backlog.insert(tri_backlog.size(), mk_tri(1, 2, 3, 3, 6, 9, 5, 10, 15, 1));
        tri_backlog.insert(tri_backlog.size(), mk_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // tiny triangle: non-trivial rounding of the normal
        tri_backlog.insert(tri_backlog.size(), mk_tri(0, 0, 0, 1, 2, 0, 3, 1, 1, 1));
        tri_backlog.insert(tri_backlog.size(), mk_tri(-1, -1, -1, 0, 0, 0, 0, 0, 0, 1));
        t.hold = 1'b1;
        tri_backlog.insert(tri_backlog.size(), t);

        for (int n = 0; n < 1500; n++)
        begin
            p = $urandom_range(99);
            for (int i = 0; i < 9; i++) t.v[i] = coord_t'($urandom);
            if (p < 30)
            begin
                // local triangle: small edges near a random anchor
                k = $urandom_range(1, 12);
                for (int i = 3; i < 9; i++)
                    t.v[i] = t.v[i % 3] + coord_t'($signed($urandom_range(0, 2 << k)) - (1 << k));
            end
            else if (p < 40)
            begin
                // collinear: C = B + m*(B-A)
                k = $urandom_range(0, 3) - 1;
                for (int i = 0; i < 3; i++)
                begin
                    t.v[i+3] = t.v[i] + coord_t'($signed($urandom_range(0, 2000)) - 1000);
                    t.v[i+6] = t.v[i+3] + coord_t'(k) * (t.v[i+3] - t.v[i]);
                end
            end
            else if (p < 45)
            begin
                // two coincident corners
                k = $urandom_range(0, 2);
                for (int i = 0; i < 3; i++) t.v[3*((k+1)%3)+i] = t.v[3*k+i];
            end
            t.corners = ($urandom_range(9) != 0);
            t.hold = (n == 700);
            tri_backlog.insert(tri_backlog.size(), t);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        while (tri_backlog.size() != 0 || start || faces_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        $display("sent %0d triangles, checked %0d results (%0d degenerate)",
                 n_sent, n_checked, n_degen);
        if (n_bad == 0 && faces_due.size() == 0)
        begin
            $display("tb_triangle_normal_and_area_core: PASS");
        end
        else
        begin
            $display("%0d failures, %0d results missing", n_bad, faces_due.size());
            $display("tb_triangle_normal_and_area_core: FAIL");
        end
        $finish;
    end

endmodule
